[rtl/core/twa_pkg.sv]
// twa_pkg: shared types, codes and constants of the trace window autoscale block.
// Standalone; used by twa_bound_track and trace_window_autoscale, not by twa_sample_mem.
`default_nettype none

package twa_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_TRACE_MODE   = 2'd0;
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd1;
  localparam logic [1:0] REG_AUTOSCALE_ON = 2'd2;

  // Input beat kinds
  localparam logic KIND_APPEND  = 1'b0;
  localparam logic KIND_RESCALE = 1'b1;

  // Trace modes
  localparam logic MODE_SCROLL = 1'b0;

  // Reciprocals for the constant divides (exact over the value ranges used)
  localparam int unsigned RECIP6        = 43691;  // ceil(2^18 / 6)
  localparam int unsigned RECIP6_SHIFT  = 18;
  localparam int unsigned RECIP20       = 52429;  // ceil(2^20 / 20)
  localparam int unsigned RECIP20_SHIFT = 20;

  // Quiet time before the bounds may shrink
  localparam logic [31:0] DECAY_MS = 32'd800;

  // Reset window length
  localparam logic [10:0] WINDOW_RESET = 11'd2;

  // Main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN_LINE,
    ST_SCAN_READ,
    ST_DRAIN,
    ST_DECIDE,
    ST_TRACK,
    ST_OUT
  } twa_state_t;

  // Request from the sequencer to the bound tracker
  typedef struct packed {
    logic        start;
    logic        clr_valid;
    logic        clr_time;
    logic [15:0] dmin;
    logic [15:0] dmax;
    logic [31:0] now;
  } twa_trk_req_t;

  // Response of the bound tracker
  typedef struct packed {
    logic        done;
    logic [15:0] low;
    logic [15:0] high;
  } twa_trk_rsp_t;

  // Saturate to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = $signed(v[15:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/twa_sample_mem.sv]
// twa_sample_mem: single-port-write, single-port-read sample store, registered read.
// No package dependencies.
`default_nettype none

module twa_sample_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/twa_bound_track.sv]
// twa_bound_track: four-stage margin/target/step pipeline and the tracked bounds.
// Depends on twa_pkg (request/response structs, reciprocals, sat16).
`default_nettype none

module twa_bound_track (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire twa_pkg::twa_trk_req_t req,
  output twa_pkg::twa_trk_rsp_t      rsp
);

  // Stage valids
  logic [3:0] v_r;

  // Stage 1: range and margin product
  logic signed [15:0] s1_dmin_r;
  logic signed [16:0] s1_dmaxa_r;
  logic        [31:0] s1_prod_r;
  logic        [31:0] s1_now_r;

  // Stage 2: targets
  logic signed [15:0] s2_tmin_r;
  logic signed [15:0] s2_tmax_r;

  // Stage 3: gaps and twentieths
  logic signed [17:0] s3_dh_r;
  logic signed [17:0] s3_dl_r;
  logic        [12:0] s3_qh_r;
  logic        [12:0] s3_ql_r;

  // Tracked state
  logic signed [15:0] track_low_r,  track_low_nxt;
  logic signed [15:0] track_high_r, track_high_nxt;
  logic               track_valid_r;
  logic        [31:0] last_ms_r;
  logic               expanded;

  logic signed [15:0] dmin_s, dmax_s;
  logic signed [16:0] dmaxa;
  logic        [15:0] rng;
  logic        [31:0] prod6;
  logic        [13:0] margin;
  logic signed [17:0] mg;
  logic signed [17:0] diffh, diffl;
  logic        [16:0] magh, magl;
  logic        [32:0] qh, ql;
  logic               may_decay;
  logic signed [17:0] hi, lo, step_h, step_l;
  logic signed [15:0] hi16, lo16;

  // Stage valid shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req.start};
    end
  end

  // Stage 1 datapath
  always_comb begin
    dmin_s = $signed(req.dmin);
    dmax_s = $signed(req.dmax);
    dmaxa  = (dmax_s <= dmin_s) ? (17'(dmin_s) + 17'sd1) : 17'(dmax_s);
    rng    = 16'(dmaxa - 17'(dmin_s));
    prod6  = 32'(rng) * 32'(twa_pkg::RECIP6);
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      s1_dmin_r  <= dmin_s;
      s1_dmaxa_r <= dmaxa;
      s1_prod_r  <= prod6;
      s1_now_r   <= req.now;
    end
  end

  // Stage 2: margin is a sixth of the range, at least one
  always_comb begin
    margin = 14'(s1_prod_r >> twa_pkg::RECIP6_SHIFT);
    if (margin == '0) begin
      margin = 14'd1;
    end
    mg = $signed(18'(margin));
  end

  always_ff @(posedge clk) begin
    if (v_r[0]) begin
      s2_tmin_r <= twa_pkg::sat16(18'(s1_dmin_r) - mg);
      s2_tmax_r <= twa_pkg::sat16(18'(s1_dmaxa_r) + mg);
    end
  end

  // Stage 3: gaps to the tracked bounds and their twentieths (magnitude)
  always_comb begin
    diffh = 18'(s2_tmax_r) - 18'(track_high_r);
    diffl = 18'(s2_tmin_r) - 18'(track_low_r);
    magh  = (diffh < 0) ? 17'(-diffh) : '0;
    magl  = (diffl > 0) ? 17'(diffl) : '0;
    qh    = 33'(magh) * 33'(twa_pkg::RECIP20);
    ql    = 33'(magl) * 33'(twa_pkg::RECIP20);
  end

  always_ff @(posedge clk) begin
    if (v_r[1]) begin
      s3_dh_r <= diffh;
      s3_dl_r <= diffl;
      s3_qh_r <= 13'(qh >> twa_pkg::RECIP20_SHIFT);
      s3_ql_r <= 13'(ql >> twa_pkg::RECIP20_SHIFT);
    end
  end

  // Stage 4: expand fast, shrink slowly, keep high above low
  always_comb begin
    may_decay = (s1_now_r >= last_ms_r) && ((s1_now_r - last_ms_r) > twa_pkg::DECAY_MS);
    step_h    = (s3_qh_r == '0) ? 18'sd1 : $signed(18'(s3_qh_r));
    step_l    = (s3_ql_r == '0) ? 18'sd1 : $signed(18'(s3_ql_r));
    hi        = 18'(track_high_r);
    lo        = 18'(track_low_r);
    expanded  = 1'b0;
    if (s3_dh_r > 18'sd0) begin
      hi       = hi + ((s3_dh_r + 18'sd1) >>> 1);
      expanded = 1'b1;
    end else if (may_decay && (s3_dh_r < -18'sd2)) begin
      hi = hi - step_h;
    end
    if (s3_dl_r < 18'sd0) begin
      lo       = lo - ((18'sd1 - s3_dl_r) >>> 1);
      expanded = 1'b1;
    end else if (may_decay && (s3_dl_r > 18'sd2)) begin
      lo = lo + step_l;
    end
    hi16 = twa_pkg::sat16(hi);
    lo16 = twa_pkg::sat16(lo);
    if (!track_valid_r) begin
      hi16     = s2_tmax_r;
      lo16     = s2_tmin_r;
      expanded = 1'b0;
    end
    if (hi16 <= lo16) begin
      if (lo16 == 16'sh7fff) begin
        lo16 = 16'sh7ffe;
      end
      hi16 = lo16 + 16'sd1;
    end
    track_low_nxt  = lo16;
    track_high_nxt = hi16;
  end

  // Tracked bounds and expansion time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_low_r   <= 16'sd0;
      track_high_r  <= 16'sd1;
      track_valid_r <= 1'b0;
      last_ms_r     <= '0;
    end else begin
      if (req.clr_valid) begin
        track_valid_r <= 1'b0;
      end else if (v_r[2]) begin
        track_valid_r <= 1'b1;
      end
      if (req.clr_time) begin
        last_ms_r <= '0;
      end else if (v_r[2] && expanded) begin
        last_ms_r <= s1_now_r;
      end
      if (v_r[2]) begin
        track_low_r  <= track_low_nxt;
        track_high_r <= track_high_nxt;
      end
    end
  end

  assign rsp.done = v_r[3];
  assign rsp.low  = track_low_r;
  assign rsp.high = track_high_r;

endmodule

`default_nettype wire

[rtl/core/trace_window_autoscale.sv]
// trace_window_autoscale: top level; sequencer, per-line ring pointers and min/max scan.
// Depends on twa_pkg, twa_sample_mem and twa_bound_track.
`default_nettype none

// Per-line sample rings with min/max autoscale. An append beat is taken while idle and
// makes one write to the sample memory; the first append into an empty line in
// oscilloscope mode instead sweeps its sample over the whole window of L entries
// (L = effective window length). With autoscale on, a rescale beat reads the held
// samples of every line holding two or more, min(fill, L) per line, through the single
// read port of the sample memory; then the result waits in the output register
// while new beats are taken. No clearing pass is needed after reset.
module trace_window_autoscale #(
  parameter int LINES      = 4,
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [10:0]        cfg_wdata,
  // input beats
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [1:0]         in_line_sel,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [31:0]        in_now_ms,
  // result beats
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_has_data,
  output logic signed [15:0]      out_scale_low,
  output logic signed [15:0]      out_scale_high
);

  localparam int LW        = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int IW        = $clog2(MAX_WINDOW);
  localparam int WW        = $clog2(MAX_WINDOW + 1);
  localparam int AW        = LW + IW;
  localparam int MEM_DEPTH = LINES * (2 ** IW);

  twa_pkg::twa_state_t state_r, state_nxt;

  // Configuration
  logic        mode_r;
  logic [10:0] wlen_r;
  logic        auto_r;
  logic        mode_chg, auto_off;

  // Per-line ring pointers
  logic [IW-1:0] head_r [LINES];
  logic [WW-1:0] fill_r [LINES];

  // Fill sweep
  logic [LW-1:0]      fill_line_r;
  logic [IW-1:0]      fill_idx_r;
  logic signed [15:0] fill_val_r;

  // Scan
  logic [LW-1:0]      scan_line_r;
  logic [IW-1:0]      scan_idx_r;
  logic [WW-1:0]      scan_left_r;
  logic               rd_vld_r;
  logic               found_r;
  logic signed [15:0] dmin_r, dmax_r;
  logic [31:0]        now_r;

  // Output register
  logic               out_valid_r;
  logic               out_has_data_r;
  logic signed [15:0] out_scale_low_r, out_scale_high_r;
  logic               out_load;

  logic [WW-1:0]   len_w;
  logic [LW-1:0]   in_line, sel_line;
  logic            line_ok, acc, app_ok, rescale_acc, sweep, last_line;
  logic [IW-1:0]   head_cur, head_n, head_inc, start_idx, idx_inc;
  logic [WW-1:0]   cnt_cur, cnt_c, h1, i1;
  logic [WW:0]     s_sum, s_wrap;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata, mem_rdata;
  logic signed [15:0] rd_s;

  twa_pkg::twa_trk_req_t trk_req;
  twa_pkg::twa_trk_rsp_t trk_rsp;

  // Effective window, limited to 2..MAX_WINDOW
  always_comb begin
    if (32'(wlen_r) < 32'd2) begin
      len_w = WW'(2);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      len_w = WW'(MAX_WINDOW);
    end else begin
      len_w = WW'(wlen_r);
    end
  end

  // Line pointer lookup, shared by append and scan
  always_comb begin
    in_line   = LW'(in_line_sel);
    line_ok   = 32'(in_line_sel) < 32'(LINES);
    sel_line  = (state_r == twa_pkg::ST_IDLE) ? in_line : scan_line_r;
    head_cur  = head_r[sel_line];
    cnt_cur   = fill_r[sel_line];
    head_n    = (WW'(head_cur) >= len_w) ? '0 : head_cur;
    h1        = WW'(head_n) + WW'(1);
    head_inc  = (h1 == len_w) ? '0 : IW'(h1);
    cnt_c     = (cnt_cur >= len_w) ? len_w : cnt_cur;
    s_sum     = (WW+1)'(head_n) + (WW+1)'(len_w) - (WW+1)'(cnt_c);
    s_wrap    = (s_sum >= (WW+1)'(len_w)) ? (s_sum - (WW+1)'(len_w)) : s_sum;
    start_idx = (cnt_c == len_w) ? '0 : IW'(s_wrap);
    i1        = WW'(scan_idx_r) + WW'(1);
    idx_inc   = (i1 == len_w) ? '0 : IW'(i1);
    last_line = (scan_line_r == LW'(LINES - 1));
  end

  // Handshake and append decode
  assign in_ready    = (state_r == twa_pkg::ST_IDLE);
  assign acc         = in_valid && in_ready;
  assign app_ok      = acc && (in_kind == twa_pkg::KIND_APPEND) && line_ok;
  assign rescale_acc = acc && (in_kind == twa_pkg::KIND_RESCALE);
  assign sweep       = app_ok && (mode_r != twa_pkg::MODE_SCROLL) && (cnt_cur == '0);

  // Configuration writes
  assign mode_chg = cfg_we && (cfg_addr == twa_pkg::REG_TRACE_MODE) && (cfg_wdata[0] != mode_r);
  assign auto_off = cfg_we && (cfg_addr == twa_pkg::REG_AUTOSCALE_ON) && !cfg_wdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= twa_pkg::MODE_SCROLL;
      wlen_r <= twa_pkg::WINDOW_RESET;
      auto_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        twa_pkg::REG_TRACE_MODE:   mode_r <= cfg_wdata[0];
        twa_pkg::REG_WINDOW_LEN:   wlen_r <= cfg_wdata;
        twa_pkg::REG_AUTOSCALE_ON: auto_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Ring pointers: a mode change empties every line
  always_ff @(posedge clk) begin
    if (!rst_n || mode_chg) begin
      head_r <= '{default: '0};
      fill_r <= '{default: '0};
    end else if (app_ok) begin
      head_r[in_line] <= head_inc;
      if (sweep) begin
        fill_r[in_line] <= len_w;
      end else if ((mode_r == twa_pkg::MODE_SCROLL) && (cnt_cur < len_w)) begin
        fill_r[in_line] <= cnt_cur + WW'(1);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      twa_pkg::ST_IDLE: begin
        if (sweep) begin
          state_nxt = twa_pkg::ST_FILL;
        end else if (rescale_acc) begin
          state_nxt = auto_r ? twa_pkg::ST_SCAN_LINE : twa_pkg::ST_OUT;
        end
      end
      twa_pkg::ST_FILL: begin
        if ((WW'(fill_idx_r) + WW'(1)) == len_w) begin
          state_nxt = twa_pkg::ST_IDLE;
        end
      end
      twa_pkg::ST_SCAN_LINE: begin
        if (cnt_cur >= WW'(2)) begin
          state_nxt = twa_pkg::ST_SCAN_READ;
        end else if (last_line) begin
          state_nxt = twa_pkg::ST_DRAIN;
        end
      end
      twa_pkg::ST_SCAN_READ: begin
        if (scan_left_r == WW'(1)) begin
          state_nxt = last_line ? twa_pkg::ST_DRAIN : twa_pkg::ST_SCAN_LINE;
        end
      end
      twa_pkg::ST_DRAIN: begin
        state_nxt = twa_pkg::ST_DECIDE;
      end
      twa_pkg::ST_DECIDE: begin
        state_nxt = found_r ? twa_pkg::ST_TRACK : twa_pkg::ST_OUT;
      end
      twa_pkg::ST_TRACK: begin
        if (trk_rsp.done) begin
          state_nxt = twa_pkg::ST_OUT;
        end
      end
      twa_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = twa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = twa_pkg::ST_IDLE;
      end
    endcase
  end

  // Oscilloscope first-sample sweep
  always_ff @(posedge clk) begin
    if (sweep) begin
      fill_line_r <= in_line;
      fill_val_r  <= in_sample_value;
    end
    if (sweep) begin
      fill_idx_r <= '0;
    end else if (state_r == twa_pkg::ST_FILL) begin
      fill_idx_r <= fill_idx_r + IW'(1);
    end
  end

  // Scan walk over lines and ring entries
  always_ff @(posedge clk) begin
    if (rescale_acc) begin
      scan_line_r <= '0;
      now_r       <= in_now_ms;
    end else if (state_r == twa_pkg::ST_SCAN_LINE) begin
      if (cnt_cur >= WW'(2)) begin
        scan_idx_r  <= start_idx;
        scan_left_r <= cnt_c;
      end else if (!last_line) begin
        scan_line_r <= scan_line_r + LW'(1);
      end
    end else if (state_r == twa_pkg::ST_SCAN_READ) begin
      scan_idx_r  <= idx_inc;
      scan_left_r <= scan_left_r - WW'(1);
      if ((scan_left_r == WW'(1)) && !last_line) begin
        scan_line_r <= scan_line_r + LW'(1);
      end
    end
  end

  // Min/max over returned read data
  assign rd_s = $signed(mem_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == twa_pkg::ST_SCAN_READ);
      if (rescale_acc) begin
        found_r <= 1'b0;
      end else if (rd_vld_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (!found_r || (rd_s < dmin_r)) begin
        dmin_r <= rd_s;
      end
      if (!found_r || (rd_s > dmax_r)) begin
        dmax_r <= rd_s;
      end
    end
  end

  // Sample memory ports
  always_comb begin
    mem_we    = (app_ok && !sweep) || (state_r == twa_pkg::ST_FILL);
    mem_waddr = (state_r == twa_pkg::ST_FILL) ? {fill_line_r, fill_idx_r} : {in_line, head_n};
    mem_wdata = (state_r == twa_pkg::ST_FILL) ? fill_val_r : in_sample_value;
    mem_re    = (state_r == twa_pkg::ST_SCAN_READ);
    mem_raddr = {scan_line_r, scan_idx_r};
  end

  twa_sample_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Bound tracker
  always_comb begin
    trk_req.start     = (state_r == twa_pkg::ST_DECIDE) && found_r;
    trk_req.clr_valid = mode_chg || auto_off;
    trk_req.clr_time  = mode_chg;
    trk_req.dmin      = dmin_r;
    trk_req.dmax      = dmax_r;
    trk_req.now       = now_r;
  end

  twa_bound_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (trk_req),
    .rsp   (trk_rsp)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_has_data_r   <= found_r;
      out_scale_low_r  <= found_r ? $signed(trk_rsp.low) : 16'sd0;
      out_scale_high_r <= found_r ? $signed(trk_rsp.high) : 16'sd1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_has_data   = out_has_data_r;
  assign out_scale_low  = out_scale_low_r;
  assign out_scale_high = out_scale_high_r;

  // Checks
  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twa_pkg::ST_FILL) |-> (WW'(fill_idx_r) < len_w))
    else $error("fill sweep index past window");

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == twa_pkg::ST_SCAN_READ) |-> ((WW'(scan_idx_r) < len_w) && !mem_we))
    else $error("scan read outside window or overlapping a write");

  a_track_start: assert property (@(posedge clk) disable iff (!rst_n)
    trk_req.start |=> (state_r == twa_pkg::ST_TRACK))
    else $error("tracker started outside a rescale");

  a_done_in_track: assert property (@(posedge clk) disable iff (!rst_n)
    trk_rsp.done |-> (state_r == twa_pkg::ST_TRACK))
    else $error("tracker result with no waiting rescale");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_data_r) |-> (out_scale_high_r > out_scale_low_r))
    else $error("upper bound not above lower bound");

endmodule

`default_nettype wire
